### rtl/ndpcm_pkg.sv
// Shared word types and constants for the nibble delta PCM decoder.
package ndpcm_pkg;

	localparam logic [3:0]  ESCAPE_NIBBLE = 4'h8;
	localparam logic [15:0] TOTAL_RESET   = 16'hFFFF;

	typedef struct packed {
		logic       stream_start;
		logic [7:0] data_byte;
	} in_word_t;

	typedef struct packed {
		logic [7:0] sample;
		logic       last_of_run;
		logic       stream_done;
	} out_word_t;

endpackage

### rtl/nibble_delta_pcm_decoder.sv
// Top level of the nibble delta PCM decoder: input stage, nibble decode, result queue.
//
//   channel   direction  handshake              word
//   in        input      in_valid / in_ready    in_data  (stream_start, data_byte)
//   out       output     out_valid / out_ready  out_data (sample, last_of_run, stream_done)
//   cfg       input      cfg_we                 cfg_wdata (total_samples)
//
// One input word is taken per cycle while the result queue has room; it decodes
// combinationally from the input register into a two-entry result queue. A word that
// yields two samples holds the input side while the queue drains. An accepted word
// passes through the input register and then the queue before its first sample. Reset
// clears the decoder state, the input stage and the queue; the sample total resets to
// 65535. An output stall backs up through the queue into the input stage.
module nibble_delta_pcm_decoder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ndpcm_pkg::in_word_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ndpcm_pkg::out_word_t out_data,
	input  logic                 cfg_we,
	input  logic [15:0]          cfg_wdata
);
	import ndpcm_pkg::*;

	typedef enum logic [1:0] {
		MODE_CODE,
		MODE_ESC_LO,
		MODE_ESC_HI
	} mode_t;

	typedef struct packed {
		logic        active;
		mode_t       mode;
		logic [3:0]  esc_low;
		logic [7:0]  run;
		logic [15:0] count;
	} dec_state_t;

	typedef struct packed {
		dec_state_t st;
		logic       emit;
		logic [7:0] smp;
		logic       done;
	} step_t;

	function automatic step_t nib_step(dec_state_t cur, logic [3:0] nib, logic [15:0] total);
		step_t       r;
		logic [7:0]  delta;
		logic [15:0] cnt_nx;
		r      = '{st: cur, emit: 1'b0, smp: cur.run, done: 1'b0};
		delta  = '0;
		cnt_nx = cur.count + 16'd1;
		if (cur.active) begin
			unique case (cur.mode)
				MODE_ESC_LO: begin
					r.st.esc_low = nib;
					r.st.mode    = MODE_ESC_HI;
				end
				MODE_ESC_HI: begin
					delta     = {nib, cur.esc_low};
					r.st.mode = MODE_CODE;
					r.emit    = 1'b1;
				end
				default: begin
					if (nib == ESCAPE_NIBBLE) begin
						r.st.mode = MODE_ESC_LO;
					end else begin
						delta     = {{4{nib[3]}}, nib};
						r.st.mode = MODE_CODE;
						r.emit    = 1'b1;
					end
				end
			endcase
			if (r.emit) begin
				r.st.run   = cur.run + delta;
				r.st.count = cnt_nx;
				r.done     = (cnt_nx >= total);
				if (r.done) begin
					r.st.active = 1'b0;
				end
				r.smp = r.st.run;
			end
		end
		return r;
	endfunction

	logic [15:0] total_q;
	dec_state_t  st_q;
	dec_state_t  st_nx;

	logic        vld_s1;
	in_word_t    word_s1;
	logic        adv_s1;

	out_word_t   head_q;
	out_word_t   tail_q;
	logic [1:0]  cnt_q;
	logic        pop;
	logic        load_ok;

	out_word_t   res0;
	out_word_t   res1;
	logic [1:0]  res_n;
	step_t       lo_step;
	step_t       hi_step;
	logic        start_done;

	assign pop       = out_valid && out_ready;
	assign load_ok   = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);
	assign adv_s1    = vld_s1 && load_ok;
	assign in_ready  = !vld_s1 || adv_s1;
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = head_q;

	always_comb begin
		lo_step    = nib_step(st_q, word_s1.data_byte[3:0], total_q);
		hi_step    = nib_step(lo_step.st, word_s1.data_byte[7:4], total_q);
		start_done = (16'd1 >= total_q);
		res0       = '0;
		res1       = '0;
		if (word_s1.stream_start) begin
			st_nx = '{active: !start_done, mode: MODE_CODE, esc_low: 4'd0,
				run: word_s1.data_byte, count: 16'd1};
			res_n = 2'd1;
			res0  = '{sample: word_s1.data_byte, last_of_run: 1'b1, stream_done: start_done};
		end else begin
			st_nx = hi_step.st;
			res_n = {1'b0, lo_step.emit} + {1'b0, hi_step.emit};
			res1  = '{sample: hi_step.smp, last_of_run: 1'b1, stream_done: hi_step.done};
			if (lo_step.emit) begin
				res0 = '{sample: lo_step.smp, last_of_run: !hi_step.emit,
					stream_done: lo_step.done};
			end else begin
				res0 = res1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= TOTAL_RESET;
			st_q    <= '{active: 1'b0, mode: MODE_CODE, esc_low: 4'd0, run: 8'd0, count: 16'd0};
			vld_s1  <= 1'b0;
			cnt_q   <= 2'd0;
		end else begin
			if (cfg_we) begin
				total_q <= cfg_wdata;
			end
			if (in_ready) begin
				vld_s1 <= in_valid;
			end
			if (adv_s1) begin
				st_q  <= st_nx;
				cnt_q <= res_n;
			end else if (pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= in_data;
		end
		if (adv_s1) begin
			head_q <= res0;
			tail_q <= res1;
		end else if (pop) begin
			head_q <= tail_q;
		end
	end

endmodule

### tb/nibble_delta_pcm_decoder_test.sv
// Self-checking testbench for the nibble delta PCM decoder: directed and random byte streams.
module nibble_delta_pcm_decoder_test;
	import ndpcm_pkg::*;

	typedef enum logic [1:0] {NIB_DELTA, NIB_ESC_LOW, NIB_ESC_HIGH} nib_mode_t;

	class delta_decode_tracker;
		logic [15:0] total;
		bit          active;
		nib_mode_t   mode;
		logic [3:0]  esc_low;
		logic [7:0]  level;
		logic [15:0] count;
		out_word_t   samples_due[$];
		int          mismatches;
		int          words_taken;
		int          samples_seen;
		int          streams_ended;

		function new();
			total         = TOTAL_RESET;
			active        = 1'b0;
			mode          = NIB_DELTA;
			esc_low       = 4'h0;
			level         = 8'h00;
			count         = 16'h0000;
			mismatches    = 0;
			words_taken   = 0;
			samples_seen  = 0;
			streams_ended = 0;
		endfunction

		function void push_sample();
			out_word_t w;
			count         = count + 16'd1;
			w.sample      = level;
			w.last_of_run = 1'b0;
			w.stream_done = (count >= total);
			samples_due.push_back(w);
			if (w.stream_done)
				active = 1'b0;
		endfunction

		function void feed_nibble(logic [3:0] nib);
			if (!active)
				return;
			if (mode == NIB_ESC_LOW) begin
				esc_low = nib;
				mode    = NIB_ESC_HIGH;
			end else if (mode == NIB_ESC_HIGH) begin
				mode  = NIB_DELTA;
				level = level + {nib, esc_low};
				push_sample();
			end else if (nib == ESCAPE_NIBBLE) begin
				mode = NIB_ESC_LOW;
			end else begin
				level = level + {{4{nib[3]}}, nib};
				push_sample();
			end
		endfunction

		function void note_word(in_word_t w);
			int        queued;
			out_word_t tail;
			queued = samples_due.size();
			words_taken++;
			if (w.stream_start) begin
				active  = 1'b1;
				mode    = NIB_DELTA;
				esc_low = 4'h0;
				level   = w.data_byte;
				count   = 16'h0000;
				push_sample();
			end else begin
				feed_nibble(w.data_byte[3:0]);
				feed_nibble(w.data_byte[7:4]);
			end
			if (samples_due.size() > queued) begin
				tail = samples_due.pop_back();
				tail.last_of_run = 1'b1;
				samples_due.push_back(tail);
			end
		endfunction

		function void check_sample(out_word_t got);
			out_word_t want;
			if (samples_due.size() == 0) begin
				$display("%0t: unexpected sample %h last_of_run %b stream_done %b",
					$time, got.sample, got.last_of_run, got.stream_done);
				mismatches++;
				return;
			end
			want = samples_due.pop_front();
			samples_seen++;
			if (want.stream_done)
				streams_ended++;
			if (got.sample !== want.sample) begin
				$display("%0t: sample expected %h actual %h", $time, want.sample, got.sample);
				mismatches++;
			end
			if (got.last_of_run !== want.last_of_run) begin
				$display("%0t: last_of_run expected %b actual %b (sample %h)",
					$time, want.last_of_run, got.last_of_run, want.sample);
				mismatches++;
			end
			if (got.stream_done !== want.stream_done) begin
				$display("%0t: stream_done expected %b actual %b (sample %h)",
					$time, want.stream_done, got.stream_done, want.sample);
				mismatches++;
			end
		endfunction
	endclass

	// start flag in bit 8, data byte below
	localparam logic [8:0] OPENING_WORDS [21] = '{
		9'h0FF, 9'h000, 9'h100, 9'h077, 9'h099, 9'h0F1, 9'h00F, 9'h000, 9'h0F7, 9'h058,
		9'h0A3, 9'h081, 9'h0FF, 9'h088, 9'h088, 9'h000, 9'h008, 9'h1FF, 9'h011, 9'h080,
		9'h180
	};
	localparam logic [8:0] SHORT_STREAM_WORDS [4] = '{9'h011, 9'h011, 9'h17F, 9'h010};

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	in_word_t    in_data   = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_word_t   out_data;
	logic        cfg_we    = 1'b0;
	logic [15:0] cfg_wdata = 16'h0000;

	int in_idle_pct  = 0;
	int out_stall_pct = 0;

	delta_decode_tracker tracker = new();

	nibble_delta_pcm_decoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_sample(out_data);
		out_ready <= ($urandom_range(99) >= out_stall_pct);
	end

	task automatic send_word(input in_word_t w);
		int gap;
		gap = 0;
		while (gap < 30 && $urandom_range(99) < in_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
		tracker.note_word(w);
	endtask

	// drop valid, drain every pending sample, then let the pipeline empty
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (tracker.samples_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_total(input logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we        <= 1'b0;
		tracker.total  = value;
	endtask

	initial begin
		in_word_t    w;
		logic [15:0] total_now;
		int          counted;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (OPENING_WORDS[i])
			send_word(in_word_t'(OPENING_WORDS[i]));
		wait_drained();
		write_total(16'd2);
		foreach (SHORT_STREAM_WORDS[i])
			send_word(in_word_t'(SHORT_STREAM_WORDS[i]));

		for (int ph = 0; ph < 8; ph++) begin
			wait_drained();
			case (ph % 4)
				0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
				1: begin in_idle_pct = 56; out_stall_pct = 0;  end
				2: begin in_idle_pct = 0;  out_stall_pct = 56; end
				default: begin in_idle_pct = 32; out_stall_pct = 32; end
			endcase
			case (ph)
				0: total_now = 16'd65535;
				1: total_now = 16'd1;
				2: total_now = 16'($urandom_range(24, 2));
				3: total_now = 16'd2;
				4: total_now = 16'($urandom_range(65535, 1));
				5: total_now = 16'($urandom_range(16, 3));
				6: total_now = 16'd65535;
				default: total_now = 16'($urandom_range(10, 4));
			endcase
			write_total(total_now);
			counted = 0;
			while (counted < 64) begin
				if (!tracker.active) begin
					w.stream_start = ($urandom_range(3) != 0);
					w.data_byte    = 8'($urandom_range(255));
				end else begin
					w.stream_start      = ($urandom_range(99) < 4);
					w.data_byte[3:0]    = ($urandom_range(3) == 0) ? ESCAPE_NIBBLE :
						4'($urandom_range(15));
					w.data_byte[7:4]    = ($urandom_range(3) == 0) ? ESCAPE_NIBBLE :
						4'($urandom_range(15));
				end
				if (w.stream_start || tracker.active)
					counted++;
				send_word(w);
			end
		end

		wait_drained();
		$display("Run took %0d words over 9 sample-total settings and 4 idle patterns;",
			tracker.words_taken);
		$display("checked %0d samples, %0d of them ending a stream.",
			tracker.samples_seen, tracker.streams_ended);
		if (tracker.mismatches == 0 && tracker.samples_due.size() == 0) begin
			$display("** nibble_delta_pcm_decoder: PASSED **");
		end else begin
			$display("** nibble_delta_pcm_decoder: FAILED **");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Timeout with %0d samples outstanding", tracker.samples_due.size());
		$display("** nibble_delta_pcm_decoder: FAILED **");
		$finish;
	end

endmodule
